[rtl/line_to_block_comment_converter_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the comment converter
// Both macros expect clk and arst_n in scope.
// ----------------------------------------------------------------------------
`ifndef LINE_TO_BLOCK_COMMENT_CONVERTER_DEFINES_SVH
`define LINE_TO_BLOCK_COMMENT_CONVERTER_DEFINES_SVH

// Implication checked in the same cycle
`define LBC_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication checked in the next cycle
`define LBC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/lbc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lbc_pkg
// Types and character constants shared by the comment converter.
// ----------------------------------------------------------------------------
package lbc_pkg;

	typedef enum logic [2:0] {
		MODE_PLAIN = 3'd0,
		MODE_BLOCK = 3'd1,
		MODE_LINE  = 3'd2,
		MODE_STR   = 3'd3,
		MODE_END   = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		PEND_NONE  = 2'd0,
		PEND_SLASH = 2'd1,
		PEND_STAR  = 2'd2
	} pend_t;

	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;

	// Saved-mode code for a string entered from a line comment
	localparam logic [1:0] SAVED_LINE = 2'd2;

	// One classified input item: up to three bytes to send
	typedef struct packed {
		logic [2:0][7:0] bytes;
		logic [1:0]      cnt;      // 1..3
		logic            has_char;
		logic            done;
	} job_t;

endpackage
`default_nettype wire

[rtl/lbc_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lbc channel interfaces
// Valid/ready channels for source bytes and converted bytes.
// ----------------------------------------------------------------------------
interface lbc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_char;
	logic       end_of_input;

	modport source (output valid, output in_char, output end_of_input, input ready);
	modport sink   (input valid, input in_char, input end_of_input, output ready);
endinterface

interface lbc_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       char_valid;
	logic       run_last;
	logic       stream_done;

	modport source (output valid, output out_char, output char_valid,
		output run_last, output stream_done, input ready);
	modport sink   (input valid, input out_char, input char_valid,
		input run_last, input stream_done, output ready);
endinterface
`default_nettype wire

[rtl/lbc_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lbc_front
// Scanner state machine: classifies each source byte; bytes with results become a job.
// ----------------------------------------------------------------------------
module lbc_front (
	input  wire              clk,
	input  wire              arst_n,
	lbc_in_if.sink           in_ch,
	output logic             push_valid,
	output lbc_pkg::job_t    push_job,
	input  wire              push_ready
);

	lbc_pkg::mode_t mode_q, mode_d;
	lbc_pkg::pend_t pend_q, pend_d;
	logic [1:0]     saved_q, saved_d;

	logic [3:0][7:0] ob;
	logic [1:0]      n;
	logic            done;
	logic [7:0]      mk;
	logic [7:0]      c;
	logic            xfer;

	assign c    = in_ch.in_char;
	assign mk   = (pend_q == lbc_pkg::PEND_STAR) ? lbc_pkg::CH_STAR : lbc_pkg::CH_SLASH;
	assign xfer = in_ch.valid && in_ch.ready;

	// Next state and emitted bytes
	always_comb begin
		mode_d  = mode_q;
		saved_d = saved_q;
		pend_d  = pend_q;
		ob      = '0;
		n       = 2'd0;
		done    = 1'b0;
		if (mode_q == lbc_pkg::MODE_PLAIN || mode_q == lbc_pkg::MODE_BLOCK ||
		    mode_q == lbc_pkg::MODE_LINE || mode_q == lbc_pkg::MODE_STR) begin
			if (in_ch.end_of_input) begin
				if (pend_q != lbc_pkg::PEND_NONE) begin
					ob[n] = mk; n = n + 2'd1;
					pend_d = lbc_pkg::PEND_NONE;
				end
				if (mode_q == lbc_pkg::MODE_LINE ||
				    (mode_q == lbc_pkg::MODE_STR && saved_q == lbc_pkg::SAVED_LINE)) begin
					ob[n] = lbc_pkg::CH_STAR;  n = n + 2'd1;
					ob[n] = lbc_pkg::CH_SLASH; n = n + 2'd1;
				end
				mode_d = lbc_pkg::MODE_END;
				done   = 1'b1;
			end else if (pend_q != lbc_pkg::PEND_NONE) begin
				// byte after a held marker goes out with the marker; a comment marker pair may be rewritten
				pend_d = lbc_pkg::PEND_NONE;
				ob[0]  = mk;
				ob[1]  = c;
				n      = 2'd2;
				case (mode_q)
					lbc_pkg::MODE_PLAIN: begin
						if (c == lbc_pkg::CH_SLASH || c == lbc_pkg::CH_STAR) begin
							ob[0]  = lbc_pkg::CH_SLASH;
							ob[1]  = lbc_pkg::CH_STAR;
							mode_d = (c == lbc_pkg::CH_SLASH) ? lbc_pkg::MODE_LINE
								: lbc_pkg::MODE_BLOCK;
						end
					end
					lbc_pkg::MODE_BLOCK: begin
						if (mk == lbc_pkg::CH_STAR && c == lbc_pkg::CH_SLASH) begin
							ob[0]  = lbc_pkg::CH_STAR;
							ob[1]  = lbc_pkg::CH_SLASH;
							mode_d = lbc_pkg::MODE_PLAIN;
						end else if (mk == lbc_pkg::CH_SLASH && c == lbc_pkg::CH_SLASH) begin
							ob[0] = lbc_pkg::CH_SPACE;
							ob[1] = lbc_pkg::CH_SPACE;
						end
					end
					lbc_pkg::MODE_LINE: begin
						if (c == lbc_pkg::CH_SLASH ||
						    (mk == lbc_pkg::CH_SLASH && c == lbc_pkg::CH_STAR)) begin
							ob[0] = lbc_pkg::CH_SPACE;
							ob[1] = lbc_pkg::CH_SPACE;
						end
					end
					default: ;
				endcase
			end else begin
				case (mode_q)
					lbc_pkg::MODE_STR: begin
						if (c == lbc_pkg::CH_QUOTE) begin
							ob[0]  = c; n = 2'd1;
							mode_d = (saved_q <= lbc_pkg::SAVED_LINE)
								? lbc_pkg::mode_t'({1'b0, saved_q}) : lbc_pkg::MODE_PLAIN;
						end else if (c == lbc_pkg::CH_NL && saved_q == lbc_pkg::SAVED_LINE) begin
							ob[0]  = lbc_pkg::CH_STAR;
							ob[1]  = lbc_pkg::CH_SLASH;
							ob[2]  = lbc_pkg::CH_NL;
							n      = 2'd3;
							mode_d = lbc_pkg::MODE_PLAIN;
						end else begin
							ob[0] = c; n = 2'd1;
						end
					end
					default: begin
						if (c == lbc_pkg::CH_STAR && mode_q != lbc_pkg::MODE_PLAIN) begin
							pend_d = lbc_pkg::PEND_STAR;
						end else if (c == lbc_pkg::CH_SLASH) begin
							pend_d = lbc_pkg::PEND_SLASH;
						end else if (c == lbc_pkg::CH_NL && mode_q == lbc_pkg::MODE_LINE) begin
							ob[0]  = lbc_pkg::CH_STAR;
							ob[1]  = lbc_pkg::CH_SLASH;
							ob[2]  = lbc_pkg::CH_NL;
							n      = 2'd3;
							mode_d = lbc_pkg::MODE_PLAIN;
						end else if (c == lbc_pkg::CH_QUOTE) begin
							ob[0]   = c; n = 2'd1;
							saved_d = mode_q[1:0];
							mode_d  = lbc_pkg::MODE_STR;
						end else begin
							ob[0] = c; n = 2'd1;
						end
					end
				endcase
			end
		end
	end

	// Job sent to the queue
	always_comb begin
		push_job.bytes    = ob[2:0];
		push_job.cnt      = (n == 2'd0) ? 2'd1 : n;
		push_job.has_char = (n != 2'd0);
		push_job.done     = done;
	end

	assign push_valid  = in_ch.valid && ((n != 2'd0) || done);
	assign in_ch.ready = push_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= lbc_pkg::MODE_PLAIN;
			saved_q <= 2'd0;
			pend_q  <= lbc_pkg::PEND_NONE;
		end else if (xfer) begin
			mode_q  <= mode_d;
			saved_q <= saved_d;
			pend_q  <= pend_d;
		end
	end

endmodule
`default_nettype wire

[rtl/lbc_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lbc_queue
// Two-entry job queue between scanner and output sequencer.
// ----------------------------------------------------------------------------
module lbc_queue (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              push_valid,
	input  lbc_pkg::job_t    push_job,
	output logic             push_ready,
	output logic             pop_valid,
	output lbc_pkg::job_t    pop_job,
	input  wire              pop
);

	lbc_pkg::job_t mem_q [2];
	logic          wr_ptr_q, rd_ptr_q;
	logic [1:0]    count_q;
	logic          do_push, do_pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_job    = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= ~wr_ptr_q;
			if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule
`default_nettype wire

[rtl/lbc_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lbc_back
// Output sequencer: sends the bytes of each job, one per transfer.
// ----------------------------------------------------------------------------
module lbc_back (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              job_valid,
	input  lbc_pkg::job_t    job,
	output logic             pop,
	lbc_out_if.source        out_ch
);

	logic [1:0] idx_q;
	logic       ovalid_q;
	logic [7:0] char_q;
	logic       cvalid_q, last_q, done_q;
	logic       load, last;

	assign load = job_valid && (!ovalid_q || out_ch.ready);
	assign last = (idx_q == job.cnt - 2'd1);
	assign pop  = load && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= 2'd0;
			ovalid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q    <= last ? 2'd0 : idx_q + 2'd1;
				ovalid_q <= 1'b1;
			end else if (out_ch.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			char_q   <= job.bytes[idx_q];
			cvalid_q <= job.has_char;
			last_q   <= last;
			done_q   <= last && job.done;
		end
	end

	assign out_ch.valid       = ovalid_q;
	assign out_ch.out_char    = char_q;
	assign out_ch.char_valid  = cvalid_q;
	assign out_ch.run_last    = last_q;
	assign out_ch.stream_done = done_q;

endmodule
`default_nettype wire

[rtl/line_to_block_comment_converter.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// line_to_block_comment_converter
// Rewrites C line comments as block comments on a byte stream.
// ----------------------------------------------------------------------------
// Source bytes come in on in_ch, one per transfer, with end_of_input set on
// the last transfer of a text. Converted bytes leave on out_ch, one per
// transfer; run_last marks the last result of an input byte and stream_done
// the last result of the whole text. A byte that opens a comment marker
// (slash outside a string, or star inside a comment) yields no result at
// once; the next byte decides what is sent. An input transfer is accepted
// whenever the two-entry job queue has room, and it takes effect on the
// scanner state at once. Results leave at one per cycle from a registered
// output stage while out_ch is ready and jobs are queued, so an input byte
// has as many output transfers as it has results: 0 to 3. After the
// end-of-text transfer all further input is taken and dropped until reset.
// ----------------------------------------------------------------------------
`include "line_to_block_comment_converter_defines.svh"

module line_to_block_comment_converter (
	input  wire         clk,
	input  wire         arst_n,
	lbc_in_if.sink      in_ch,
	lbc_out_if.source   out_ch
);

	// Front to queue
	logic          push_valid, push_ready;
	lbc_pkg::job_t push_job;

	// Queue to back
	logic          job_valid, pop;
	lbc_pkg::job_t job;

	// Scanner: mode tracking and byte classification
	lbc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.push_valid (push_valid),
		.push_job   (push_job),
		.push_ready (push_ready)
	);

	// Decouples scanner from a stalled output
	lbc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_job   (push_job),
		.push_ready (push_ready),
		.pop_valid  (job_valid),
		.pop_job    (job),
		.pop        (pop)
	);

	// Serializes each job onto the output channel
	lbc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job       (job),
		.pop       (pop),
		.out_ch    (out_ch)
	);

	// Checks
	`LBC_ASSERT_IMPL(a_done_is_last, out_ch.valid && out_ch.stream_done, out_ch.run_last, "stream_done without run_last")
	`LBC_ASSERT_IMPL(a_empty_is_done, out_ch.valid && !out_ch.char_valid, out_ch.stream_done && out_ch.out_char == 8'h00, "empty result outside end of text")
	`LBC_ASSERT_NEXT(a_quiet_after_done, out_ch.valid && out_ch.ready && out_ch.stream_done, !out_ch.valid, "output after end of text")

endmodule
`default_nettype wire
